// ===== design/wuf_pkg.sv =====
// Shared constants and memory request types for the weighted union-find unit.
package wuf_pkg;

  localparam int unsigned NUM_ELEMENTS = 128;
  localparam int unsigned IDX_W        = $clog2(NUM_ELEMENTS);
  localparam int unsigned SIZE_W       = $clog2(NUM_ELEMENTS + 1);
  localparam int unsigned ELEM_W       = 7;

  localparam logic KIND_UNION = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
  } par_req_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [SIZE_W-1:0] wr_data;
  } size_req_t;

endpackage

// ===== design/weighted_union_find_unit.sv =====
// Top level of the weighted union-find unit: stream ports, sequencer and tables.
//
// Disjoint-set engine over 128 elements. Each input word names two elements
// (elem_p, elem_q) and, in tuser, a kind: 0 joins their sets, 1 only tests
// them. Each word gives exactly one output word with same_set and the roots
// found for both elements before any linking.
// Both root searches do path halving in the parent table, p first, then q;
// a join links the root of the smaller tree under the larger one, q's root
// under p's root on a tie.
// Items are handled one at a time. Each halving step of either search is a parent
// read and a grandparent read through the one read port of the parent table,
// and linking two trees reads the size table for both roots, then writes back
// the sum. s_axis_tready_o is high while idle.
// Reset puts every element in a set of its own; per-entry valid bits make an
// unwritten entry read as its reset value, so no clearing pass is needed and
// the block takes words right after reset.
// The result sits in an output register; a new word is accepted while it
// waits, and the block stalls before writing the next result until the
// receiver has taken the previous one.
module weighted_union_find_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [6:0] elem_p, [13:7] elem_q, [15:14] zero
  input  logic        s_axis_tuser_i,   // [0] kind
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [0] same_set, [7:1] root_p, [14:8] root_q, [15] zero
);

  wuf_pkg::par_req_t                 par_req;
  wuf_pkg::size_req_t                size_req;
  logic [wuf_pkg::IDX_W-1:0]         par_rd_data;
  logic [wuf_pkg::SIZE_W-1:0]        size_rd_data;
  logic                              same_set;
  logic [wuf_pkg::ELEM_W-1:0]        root_p;
  logic [wuf_pkg::ELEM_W-1:0]        root_q;

  wuf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .kind_i         (s_axis_tuser_i),
    .elem_p_i       (s_axis_tdata_i[6:0]),
    .elem_q_i       (s_axis_tdata_i[13:7]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .same_set_o     (same_set),
    .root_p_o       (root_p),
    .root_q_o       (root_q),
    .par_req_o      (par_req),
    .par_rd_data_i  (par_rd_data),
    .size_req_o     (size_req),
    .size_rd_data_i (size_rd_data)
  );

  wuf_parent_mem u_parent_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (par_req),
    .rd_data_o (par_rd_data)
  );

  wuf_size_mem u_size_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (size_req),
    .rd_data_o (size_rd_data)
  );

  assign m_axis_tdata_o = {1'b0, root_q, root_p, same_set};

endmodule

// ===== design/wuf_parent_mem.sv =====
// Parent table: synchronous memory where an unwritten entry reads as its own index.
module wuf_parent_mem (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wuf_pkg::par_req_t          req_i,
  output logic [wuf_pkg::IDX_W-1:0]  rd_data_o
);

  logic [wuf_pkg::IDX_W-1:0] mem_q [wuf_pkg::NUM_ELEMENTS];
  logic [wuf_pkg::NUM_ELEMENTS-1:0] valid_q;
  logic [wuf_pkg::IDX_W-1:0] raw_q;
  logic [wuf_pkg::IDX_W-1:0] addr_q;
  logic                      hit_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      raw_q  <= mem_q[req_i.rd_addr];
      addr_q <= req_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        hit_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  // An entry never written is still a root of its own.
  assign rd_data_o = hit_q ? raw_q : addr_q;

endmodule

// ===== design/wuf_size_mem.sv =====
// Tree-size table: synchronous memory where an unwritten entry reads as one.
module wuf_size_mem (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wuf_pkg::size_req_t          req_i,
  output logic [wuf_pkg::SIZE_W-1:0]  rd_data_o
);

  logic [wuf_pkg::SIZE_W-1:0] mem_q [wuf_pkg::NUM_ELEMENTS];
  logic [wuf_pkg::NUM_ELEMENTS-1:0] valid_q;
  logic [wuf_pkg::SIZE_W-1:0] raw_q;
  logic                       hit_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      raw_q <= mem_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        hit_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = hit_q ? raw_q : wuf_pkg::SIZE_W'(1);

endmodule

// ===== design/wuf_ctrl.sv =====
// Sequencer: root searches with path halving, weighted linking and the result register.
module wuf_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic [wuf_pkg::ELEM_W-1:0]  elem_p_i,
  input  logic [wuf_pkg::ELEM_W-1:0]  elem_q_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        same_set_o,
  output logic [wuf_pkg::ELEM_W-1:0]  root_p_o,
  output logic [wuf_pkg::ELEM_W-1:0]  root_q_o,
  output wuf_pkg::par_req_t           par_req_o,
  input  logic [wuf_pkg::IDX_W-1:0]   par_rd_data_i,
  output wuf_pkg::size_req_t          size_req_o,
  input  logic [wuf_pkg::SIZE_W-1:0]  size_rd_data_i
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CHK  = 6'b000010,
    S_GP   = 6'b000100,
    S_SZP  = 6'b001000,
    S_LINK = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic                       kind_q, kind_d;
  logic                       phase_q, phase_d;
  logic [wuf_pkg::IDX_W-1:0]  cur_q, cur_d;
  logic [wuf_pkg::IDX_W-1:0]  eq_q, eq_d;
  logic [wuf_pkg::IDX_W-1:0]  rp_q, rp_d;
  logic [wuf_pkg::IDX_W-1:0]  rq_q, rq_d;
  logic [wuf_pkg::SIZE_W-1:0] szp_q, szp_d;
  logic                       out_valid_q, out_valid_d;
  logic                       same_q, same_d;
  logic [wuf_pkg::ELEM_W-1:0] orp_q, orp_d;
  logic [wuf_pkg::ELEM_W-1:0] orq_q, orq_d;
  logic [wuf_pkg::SIZE_W-1:0] size_sum;
  logic                       p_smaller;

  assign in_ready_o = (state_q == S_IDLE);
  assign size_sum   = szp_q + size_rd_data_i;
  assign p_smaller  = (szp_q < size_rd_data_i);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    phase_d     = phase_q;
    cur_d       = cur_q;
    eq_d        = eq_q;
    rp_d        = rp_q;
    rq_d        = rq_q;
    szp_d       = szp_q;
    out_valid_d = out_valid_q;
    same_d      = same_q;
    orp_d       = orp_q;
    orq_d       = orq_q;
    par_req_o   = '0;
    size_req_o  = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d            = kind_i;
          phase_d           = 1'b0;
          cur_d             = wuf_pkg::IDX_W'(elem_p_i);
          eq_d              = wuf_pkg::IDX_W'(elem_q_i);
          par_req_o.rd_en   = 1'b1;
          par_req_o.rd_addr = wuf_pkg::IDX_W'(elem_p_i);
          state_d           = S_CHK;
        end
      end
      S_CHK: begin
        if (par_rd_data_i == cur_q) begin
          if (!phase_q) begin
            // Root of p found; start the search for q.
            rp_d              = cur_q;
            phase_d           = 1'b1;
            cur_d             = eq_q;
            par_req_o.rd_en   = 1'b1;
            par_req_o.rd_addr = eq_q;
          end else begin
            rq_d = cur_q;
            if (kind_q == wuf_pkg::KIND_UNION && rp_q != cur_q) begin
              size_req_o.rd_en   = 1'b1;
              size_req_o.rd_addr = rp_q;
              state_d            = S_SZP;
            end else begin
              state_d = S_OUT;
            end
          end
        end else begin
          par_req_o.rd_en   = 1'b1;
          par_req_o.rd_addr = par_rd_data_i;
          state_d           = S_GP;
        end
      end
      S_GP: begin
        // Point the current entry at its grandparent and step there.
        par_req_o.wr_en   = 1'b1;
        par_req_o.wr_addr = cur_q;
        par_req_o.wr_data = par_rd_data_i;
        par_req_o.rd_en   = 1'b1;
        par_req_o.rd_addr = par_rd_data_i;
        cur_d             = par_rd_data_i;
        state_d           = S_CHK;
      end
      S_SZP: begin
        szp_d              = size_rd_data_i;
        size_req_o.rd_en   = 1'b1;
        size_req_o.rd_addr = rq_q;
        state_d            = S_LINK;
      end
      S_LINK: begin
        par_req_o.wr_en    = 1'b1;
        size_req_o.wr_en   = 1'b1;
        size_req_o.wr_data = size_sum;
        if (p_smaller) begin
          par_req_o.wr_addr  = rp_q;
          par_req_o.wr_data  = rq_q;
          size_req_o.wr_addr = rq_q;
        end else begin
          par_req_o.wr_addr  = rq_q;
          par_req_o.wr_data  = rp_q;
          size_req_o.wr_addr = rp_q;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          same_d      = (rp_q == rq_q);
          orp_d       = wuf_pkg::ELEM_W'(rp_q);
          orq_d       = wuf_pkg::ELEM_W'(rq_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    phase_q <= phase_d;
    cur_q   <= cur_d;
    eq_q    <= eq_d;
    rp_q    <= rp_d;
    rq_q    <= rq_d;
    szp_q   <= szp_d;
    same_q  <= same_d;
    orp_q   <= orp_d;
    orq_q   <= orq_d;
  end

  assign out_valid_o = out_valid_q;
  assign same_set_o  = same_q;
  assign root_p_o    = orp_q;
  assign root_q_o    = orq_q;

endmodule

// ===== tb/weighted_union_find_unit_tb.sv =====
// Self-checking stream testbench for the weighted union-find unit with its own forest model.
`timescale 1ns / 1ps

module weighted_union_find_unit_tb;

  typedef struct packed {
    logic                       settle;  // hold this word back until every result is in
    logic                       kind;
    logic [wuf_pkg::ELEM_W-1:0] p;
    logic [wuf_pkg::ELEM_W-1:0] q;
  } pair_req_t;

  typedef struct packed {
    logic                       same;
    logic [wuf_pkg::ELEM_W-1:0] rp;
    logic [wuf_pkg::ELEM_W-1:0] rq;
  } roots_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [6:0] elem_p, [13:7] elem_q, [15:14] zero
  logic        s_tuser = 1'b0; // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [0] same_set, [7:1] root_p, [14:8] root_q, [15] zero

  pair_req_t pending_pairs[$];
  roots_t    roots_due[$];

  logic [wuf_pkg::IDX_W-1:0]  forest_parent [wuf_pkg::NUM_ELEMENTS];
  logic [wuf_pkg::SIZE_W-1:0] forest_weight [wuf_pkg::NUM_ELEMENTS];

  int unsigned sent_cnt = 0;
  int unsigned recv_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned hold_cnt = 0;
  logic        held_long = 1'b0;
  int unsigned mismatches = 0;

  weighted_union_find_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Root search with path halving: every visited entry skips to its grandparent.
  function automatic logic [wuf_pkg::IDX_W-1:0] climb_to_root(
      input logic [wuf_pkg::IDX_W-1:0] start);
    logic [wuf_pkg::IDX_W-1:0] node;
    int unsigned               hops;
    node = start;
    hops = 0;
    while (forest_parent[node] != node && hops < wuf_pkg::NUM_ELEMENTS) begin
      forest_parent[node] = forest_parent[forest_parent[node]];
      node = forest_parent[node];
      hops++;
    end
    return node;
  endfunction

  function automatic roots_t join_or_test(input logic kind,
                                          input logic [wuf_pkg::ELEM_W-1:0] p,
                                          input logic [wuf_pkg::ELEM_W-1:0] q);
    roots_t                    res;
    logic [wuf_pkg::IDX_W-1:0] rp;
    logic [wuf_pkg::IDX_W-1:0] rq;
    rp = climb_to_root(wuf_pkg::IDX_W'(p % wuf_pkg::NUM_ELEMENTS));
    rq = climb_to_root(wuf_pkg::IDX_W'(q % wuf_pkg::NUM_ELEMENTS));
    res.same = (rp == rq);
    res.rp = wuf_pkg::ELEM_W'(rp);
    res.rq = wuf_pkg::ELEM_W'(rq);
    if (kind == wuf_pkg::KIND_UNION && !res.same) begin
      if (forest_weight[rp] < forest_weight[rq]) begin
        forest_parent[rp] = rq;
        forest_weight[rq] = forest_weight[rq] + forest_weight[rp];
      end else begin
        forest_parent[rq] = rp;
        forest_weight[rp] = forest_weight[rp] + forest_weight[rq];
      end
    end
    return res;
  endfunction

  task automatic add_pair(input logic kind, input int unsigned p, input int unsigned q,
                          input logic settle = 1'b0);
    pair_req_t r;
    r.settle = settle;
    r.kind = kind;
    r.p = wuf_pkg::ELEM_W'(p);
    r.q = wuf_pkg::ELEM_W'(q);
    pending_pairs = {pending_pairs, r};
  endtask

  // Sender: predicts each accepted word; the next comes after a random gap, none when calm.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
      send_gap <= 0;
      sent_cnt <= 0;
    end else begin : drive
      int unsigned accepted;
      logic        calm;
      pair_req_t   nxt;
      roots_t      due;
      accepted = sent_cnt;
      if (s_tvalid && s_tready) begin
        due = join_or_test(s_tuser, s_tdata[6:0], s_tdata[13:7]);
        roots_due = {roots_due, due};
        accepted = sent_cnt + 1;
        sent_cnt <= accepted;
      end
      calm = ((accepted / 128) % 4) == 3;
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_pairs.size() != 0 &&
                     (!pending_pairs[0].settle || accepted == recv_cnt)) begin
          nxt = pending_pairs.pop_front();
          s_tdata  <= {2'b00, nxt.q, nxt.p};
          s_tuser  <= nxt.kind;
          s_tvalid <= 1'b1;
          send_gap <= calm ? 0 : pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every result word and stalls at random, once for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      recv_cnt  <= 0;
      hold_cnt  <= 0;
      held_long <= 1'b0;
    end else begin : observe
      roots_t got;
      roots_t want;
      if (m_tvalid && m_tready) begin
        got.same = m_tdata[0];
        got.rp = m_tdata[7:1];
        got.rq = m_tdata[14:8];
        if (roots_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word %h arrived with nothing outstanding", $time, m_tdata);
        end else begin
          want = roots_due.pop_front();
          if (got.same !== want.same || got.rp !== want.rp || got.rq !== want.rq) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: result %0d expected same=%0d rp=%0d rq=%0d, ",
                        "got same=%0d rp=%0d rq=%0d"},
                       $time, recv_cnt, want.same, want.rp, want.rq,
                       got.same, got.rp, got.rq);
          end
        end
        recv_cnt <= recv_cnt + 1;
      end
      if (!held_long && recv_cnt >= 300) begin
        held_long <= 1'b1;
        hold_cnt  <= 400;
        m_tready  <= 1'b0;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (((recv_cnt / 128) % 4) != 1 && $urandom_range(0, 3) == 0)
          hold_cnt <= pick_gap();
      end
    end
  end

  initial begin
    #10_000_000;
    $display("** weighted_union_find_unit: FAILED **");
    $finish;
  end

  initial begin
    int unsigned blk;
    for (int k = 0; k < wuf_pkg::NUM_ELEMENTS; k++) begin
      forest_parent[k] = wuf_pkg::IDX_W'(k);
      forest_weight[k] = wuf_pkg::SIZE_W'(1);
    end

    // Directed: reset forest, same element twice, ties, both link directions,
    // repeated joins and chains deep enough for halving.
    add_pair(wuf_pkg::KIND_QUERY, 0, 0);
    add_pair(wuf_pkg::KIND_QUERY, 0, 127);
    add_pair(wuf_pkg::KIND_UNION, 127, 127);
    add_pair(wuf_pkg::KIND_UNION, 0, 1);
    add_pair(wuf_pkg::KIND_UNION, 1, 0);
    add_pair(wuf_pkg::KIND_UNION, 2, 3);
    add_pair(wuf_pkg::KIND_UNION, 0, 2);
    add_pair(wuf_pkg::KIND_UNION, 4, 5);
    add_pair(wuf_pkg::KIND_UNION, 6, 7);
    add_pair(wuf_pkg::KIND_UNION, 4, 6);
    add_pair(wuf_pkg::KIND_UNION, 7, 3);
    add_pair(wuf_pkg::KIND_QUERY, 3, 1);
    add_pair(wuf_pkg::KIND_QUERY, 3, 7);
    add_pair(wuf_pkg::KIND_UNION, 8, 0);
    add_pair(wuf_pkg::KIND_UNION, 0, 9);
    add_pair(wuf_pkg::KIND_UNION, 127, 126);
    add_pair(wuf_pkg::KIND_UNION, 85, 42);
    add_pair(wuf_pkg::KIND_QUERY, 42, 85);
    add_pair(wuf_pkg::KIND_UNION, 127, 0);
    add_pair(wuf_pkg::KIND_QUERY, 127, 3);
    add_pair(wuf_pkg::KIND_QUERY, 126, 85);

    // Joins inside groups of sixteen build several mid-sized trees first.
    for (int i = 0; i < 350; i++) begin
      blk = $urandom_range(0, 7);
      add_pair($urandom_range(0, 9) < 6 ? wuf_pkg::KIND_UNION : wuf_pkg::KIND_QUERY,
               blk * 16 + $urandom_range(0, 15), blk * 16 + $urandom_range(0, 15));
    end
    // Then sparse joins across the whole range among many queries.
    for (int i = 0; i < 800; i++)
      add_pair($urandom_range(0, 99) < 12 ? wuf_pkg::KIND_UNION : wuf_pkg::KIND_QUERY,
               $urandom_range(0, 127), $urandom_range(0, 127), i == 0 || i == 400);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (pending_pairs.size() != 0 || s_tvalid) @(posedge clk_i);
    while (recv_cnt != sent_cnt) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    if (mismatches == 0 && roots_due.size() == 0) begin
      $display("** weighted_union_find_unit: PASSED **");
    end else begin
      $display("** weighted_union_find_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/wuf_pkg.sv
design/wuf_parent_mem.sv
design/wuf_size_mem.sv
design/wuf_ctrl.sv
design/weighted_union_find_unit.sv
tb/weighted_union_find_unit_tb.sv
